FILE: rtl/dq_pkg.sv
package dq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        CMD_INS_REAR  = 3'd0,
        CMD_INS_FRONT = 3'd1,
        CMD_REM_FRONT = 3'd2,
        CMD_REM_REAR  = 3'd3,
        CMD_REM_VALUE = 3'd4,
        CMD_LIST      = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_SHIFT,
        S_LIST,
        S_EMIT,
        S_EMIT_RD
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [DATA_W-1:0] value;
        logic [4:0]        count;
        logic              last;
    } t_emit;

    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY)) begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/dq_ram.sv
module dq_ram (
    input  logic                       i_clk,
    input  dq_pkg::t_ram_req           i_req,
    output logic [dq_pkg::DATA_W-1:0]  o_rdata
);

    logic [dq_pkg::DATA_W-1:0] r_mem [dq_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

FILE: rtl/dq_ctrl.sv
module dq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [2:0]                 i_command,
    input  logic [dq_pkg::DATA_W-1:0]  i_operand_value,
    input  logic                       i_ready,
    output dq_pkg::t_emit              o_emit,
    output dq_pkg::t_ram_req           o_ram,
    input  logic [dq_pkg::DATA_W-1:0]  i_rdata
);

    dq_pkg::t_state                r_state, n_state;
    dq_pkg::t_cmd                  r_cmd, n_cmd;
    logic [dq_pkg::DATA_W-1:0]     r_val, n_val;
    logic [dq_pkg::IDX_W-1:0]      r_head, n_head;
    logic [dq_pkg::CNT_W-1:0]      r_occ, n_occ;
    logic [dq_pkg::IDX_W-1:0]      r_idx, n_idx;
    dq_pkg::t_status               r_status, n_status;
    logic [dq_pkg::DATA_W-1:0]     r_value, n_value;

    logic [dq_pkg::CNT_W-1:0]      nxt1, nxt2;
    logic [dq_pkg::IDX_W-1:0]      prev_head;
    logic                          full, empty;

    assign nxt1      = dq_pkg::CNT_W'(r_idx) + dq_pkg::CNT_W'(1);
    assign nxt2      = dq_pkg::CNT_W'(r_idx) + dq_pkg::CNT_W'(2);
    assign prev_head = (r_head == '0) ? dq_pkg::IDX_W'(dq_pkg::CAPACITY - 1)
                                      : r_head - dq_pkg::IDX_W'(1);
    assign full      = (r_occ == dq_pkg::CNT_W'(dq_pkg::CAPACITY));
    assign empty     = (r_occ == '0);
    assign o_in_stall = (r_state != dq_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::S_IDLE;
            r_head  <= '0;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_value  <= n_value;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_val    = r_val;
        n_head   = r_head;
        n_occ    = r_occ;
        n_idx    = r_idx;
        n_status = r_status;
        n_value  = r_value;
        o_ram       = '0;
        o_ram.wdata = r_val;
        o_emit       = '0;
        o_emit.count = 5'(r_occ);
        case (r_state)
            dq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = dq_pkg::t_cmd'(i_command);
                    n_val   = i_operand_value;
                    n_state = dq_pkg::S_EXEC;
                end
            end
            dq_pkg::S_EXEC: begin
                n_value  = '0;
                n_status = dq_pkg::ST_OK;
                n_state  = dq_pkg::S_EMIT;
                case (r_cmd)
                    dq_pkg::CMD_INS_REAR: begin
                        if (full) begin
                            n_status = dq_pkg::ST_FULL;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = dq_pkg::slot(r_head, dq_pkg::IDX_W'(r_occ));
                            n_occ       = r_occ + dq_pkg::CNT_W'(1);
                        end
                    end
                    dq_pkg::CMD_INS_FRONT: begin
                        if (full) begin
                            n_status = dq_pkg::ST_FULL;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = prev_head;
                            n_head      = prev_head;
                            n_occ       = r_occ + dq_pkg::CNT_W'(1);
                        end
                    end
                    dq_pkg::CMD_REM_FRONT: begin
                        if (empty) begin
                            n_status = dq_pkg::ST_EMPTY;
                        end else begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = r_head;
                            n_head      = dq_pkg::slot(r_head, dq_pkg::IDX_W'(1));
                            n_occ       = r_occ - dq_pkg::CNT_W'(1);
                            n_state     = dq_pkg::S_EMIT_RD;
                        end
                    end
                    dq_pkg::CMD_REM_REAR: begin
                        if (empty) begin
                            n_status = dq_pkg::ST_EMPTY;
                        end else begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = dq_pkg::slot(r_head,
                                              dq_pkg::IDX_W'(r_occ - dq_pkg::CNT_W'(1)));
                            n_occ       = r_occ - dq_pkg::CNT_W'(1);
                            n_state     = dq_pkg::S_EMIT_RD;
                        end
                    end
                    dq_pkg::CMD_REM_VALUE, dq_pkg::CMD_LIST: begin
                        if (empty) begin
                            n_status = dq_pkg::ST_EMPTY;
                        end else begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = r_head;
                            n_idx       = '0;
                            n_state     = (r_cmd == dq_pkg::CMD_LIST) ? dq_pkg::S_LIST
                                                                       : dq_pkg::S_SEARCH;
                        end
                    end
                    default: begin
                        n_status = dq_pkg::ST_OK;
                    end
                endcase
            end
            dq_pkg::S_SEARCH: begin
                if (i_rdata == r_val) begin
                    n_value = i_rdata;
                    if (nxt1 < r_occ) begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = dq_pkg::slot(r_head, dq_pkg::IDX_W'(nxt1));
                        n_state     = dq_pkg::S_SHIFT;
                    end else begin
                        n_occ    = r_occ - dq_pkg::CNT_W'(1);
                        n_status = dq_pkg::ST_OK;
                        n_state  = dq_pkg::S_EMIT;
                    end
                end else if (nxt1 == r_occ) begin
                    n_status = dq_pkg::ST_NOT_FOUND;
                    n_state  = dq_pkg::S_EMIT;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = dq_pkg::slot(r_head, dq_pkg::IDX_W'(nxt1));
                    n_idx       = dq_pkg::IDX_W'(nxt1);
                end
            end
            dq_pkg::S_SHIFT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = dq_pkg::slot(r_head, r_idx);
                o_ram.wdata = i_rdata;
                if (nxt2 < r_occ) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = dq_pkg::slot(r_head, dq_pkg::IDX_W'(nxt2));
                    n_idx       = dq_pkg::IDX_W'(nxt1);
                end else begin
                    n_occ    = r_occ - dq_pkg::CNT_W'(1);
                    n_status = dq_pkg::ST_OK;
                    n_state  = dq_pkg::S_EMIT;
                end
            end
            dq_pkg::S_LIST: begin
                o_emit.valid  = 1'b1;
                o_emit.status = dq_pkg::ST_OK;
                o_emit.value  = i_rdata;
                o_emit.last   = (nxt1 == r_occ);
                if (i_ready) begin
                    if (nxt1 == r_occ) begin
                        n_state = dq_pkg::S_IDLE;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = dq_pkg::slot(r_head, dq_pkg::IDX_W'(nxt1));
                        n_idx       = dq_pkg::IDX_W'(nxt1);
                    end
                end
            end
            dq_pkg::S_EMIT: begin
                o_emit.valid  = 1'b1;
                o_emit.status = r_status;
                o_emit.value  = r_value;
                o_emit.last   = 1'b1;
                if (i_ready) begin
                    n_state = dq_pkg::S_IDLE;
                end
            end
            dq_pkg::S_EMIT_RD: begin
                o_emit.valid  = 1'b1;
                o_emit.status = dq_pkg::ST_OK;
                o_emit.value  = i_rdata;
                o_emit.last   = 1'b1;
                if (i_ready) begin
                    n_state = dq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/deque_with_value_removal_core.sv
// Bounded double-ended queue of signed 32-bit entries held in a single-port-write,
// registered-read RAM of CAPACITY words and walked by a small sequencer. One command
// is taken at a time. Inserts and front or rear removals pass from accept through the
// execute state and an emit state to the output register; a removal by value reads
// entries until a match or the end, moving later ones forward, and a list emits every
// entry, all stretched by any output stall. The one-entry-per-cycle RAM read, held in a
// list while the output stalls, sets the length of every walk. Each command yields one
// beat, or one beat per entry for a list, and its final beat carries last_result.
module deque_with_value_removal_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [2:0]                 i_command,
    input  logic signed [31:0]         i_operand_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic signed [31:0]         o_entry_value,
    output logic [4:0]                 o_entry_count,
    output logic                       o_last_result
);

    dq_pkg::t_emit              emit;
    dq_pkg::t_ram_req           ram_req;
    logic [dq_pkg::DATA_W-1:0]  rdata;
    logic                       emit_ready;

    logic                       r_out_valid;
    logic [1:0]                 r_status;
    logic [31:0]                r_value;
    logic [4:0]                 r_count;
    logic                       r_last;

    assign emit_ready = !r_out_valid || !i_out_stall;

    dq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_operand_value (i_operand_value),
        .i_ready         (emit_ready),
        .o_emit          (emit),
        .o_ram           (ram_req),
        .i_rdata         (rdata)
    );

    dq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_ready) begin
            r_out_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ready && emit.valid) begin
            r_status <= emit.status;
            r_value  <= emit.value;
            r_count  <= emit.count;
            r_last   <= emit.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_entry_count = r_count;
    assign o_last_result = r_last;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Block accepted a command without going busy.");

    a_partial_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_result) |-> (o_status == dq_pkg::ST_OK))
        else $error("Intermediate list beat carries a non-ok status.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == dq_pkg::ST_FULL)
            |-> (o_entry_count == 5'(dq_pkg::CAPACITY)))
        else $error("Full status reported while the store is not full.");

    a_empty_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == dq_pkg::ST_EMPTY)
            |-> (o_entry_count == 5'd0 && o_entry_value == 32'sd0 && o_last_result))
        else $error("Empty status beat is malformed.");

endmodule
